// File: hw/rtl/assert_macros.svh
// Assertion helpers; expect clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KPC_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KPC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/kpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared constants, types and helpers of the k-mer position counter.
// ----------------------------------------------------------------------------
package kpc_pkg;

	localparam int MAX_POS    = 256;
	localparam int POS_W      = $clog2(MAX_POS);
	localparam int KLEN       = 5;
	localparam int KMER_W     = 2 * KLEN;
	localparam int RUN_W      = 3;
	localparam int CNT_W      = 32;
	localparam int TRIM_W     = 9;
	localparam int CMP_W      = (POS_W + 1 > 9) ? POS_W + 1 : 9;
	localparam int TOT_AW     = 1 + KMER_W;
	localparam int PC_AW      = 1 + KMER_W + POS_W;
	localparam int TOT_DEPTH  = 2 ** TOT_AW;
	localparam int PC_DEPTH   = 2 ** PC_AW;
	localparam int FIFO_DEPTH = 3;
	localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] BASE_N = 8'd78;

	localparam logic MODE_PUSH  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [2:0] ST_UNTRIMMED = 3'd0;
	localparam logic [2:0] ST_RIGHT     = 3'd1;
	localparam logic [2:0] ST_LEFT      = 3'd2;
	localparam logic [2:0] ST_BOTH      = 3'd3;
	localparam logic [2:0] ST_INVALID   = 3'd4;

	localparam logic CFG_LEFT_TRIM  = 1'b0;
	localparam logic CFG_RIGHT_TRIM = 1'b1;

	typedef struct packed {
		logic              valid;
		logic              query;
		logic              inc;
		logic              pc_en;
		logic [TOT_AW-1:0] tot_addr;
		logic [PC_AW-1:0]  pc_addr;
	} mem_req_t;

	typedef struct packed {
		logic             valid;
		logic [CNT_W-1:0] total;
		logic [CNT_W-1:0] pos_count;
	} mem_rsp_t;

	typedef struct packed {
		logic busy;
		logic query_s1;
	} mem_stat_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
		sat_inc = (&x) ? x : x + CNT_W'(1);
	endfunction

endpackage

// File: hw/rtl/kpc_count_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpc_count_mem
// Total and per-position counter memories: read at request, saturating
// increment and write-back in the cycle after, with write forwarding and a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module kpc_count_mem (
	input  logic                clk,
	input  logic                arst_n,
	input  kpc_pkg::mem_req_t   req,
	output kpc_pkg::mem_rsp_t   rsp,
	output kpc_pkg::mem_stat_t  stat
);
	import kpc_pkg::*;

	logic [CNT_W-1:0] tot_mem [TOT_DEPTH];
	logic [CNT_W-1:0] pc_mem  [PC_DEPTH];

	logic [PC_AW:0]    clr_q;
	logic              busy;
	logic              vld_s1;
	mem_req_t          req_s1;
	logic [CNT_W-1:0]  tot_rd_s1;
	logic [CNT_W-1:0]  pc_rd_s1;

	logic              twr_vld_q;
	logic [TOT_AW-1:0] twr_addr_q;
	logic [CNT_W-1:0]  twr_data_q;
	logic              pwr_vld_q;
	logic [PC_AW-1:0]  pwr_addr_q;
	logic [CNT_W-1:0]  pwr_data_q;

	logic [CNT_W-1:0]  tot_cur;
	logic [CNT_W-1:0]  pc_cur;
	logic              tot_inc;
	logic              pc_inc;
	logic              tot_we;
	logic              pc_we;
	logic [TOT_AW-1:0] tot_wa;
	logic [PC_AW-1:0]  pc_wa;
	logic [CNT_W-1:0]  tot_wd;
	logic [CNT_W-1:0]  pc_wd;

	assign busy = !clr_q[PC_AW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			vld_s1    <= 1'b0;
			twr_vld_q <= 1'b0;
			pwr_vld_q <= 1'b0;
		end else begin
			if (busy) begin
				clr_q <= clr_q + (PC_AW + 1)'(1);
			end
			vld_s1    <= req.valid;
			twr_vld_q <= tot_inc;
			pwr_vld_q <= pc_inc;
		end
	end

	always_ff @(posedge clk) begin
		req_s1     <= req;
		twr_addr_q <= req_s1.tot_addr;
		twr_data_q <= tot_wd;
		pwr_addr_q <= req_s1.pc_addr;
		pwr_data_q <= pc_wd;
	end

	// forward the write that landed on the edge of our read
	assign tot_cur = (twr_vld_q && twr_addr_q == req_s1.tot_addr) ? twr_data_q : tot_rd_s1;
	assign pc_cur  = (pwr_vld_q && pwr_addr_q == req_s1.pc_addr) ? pwr_data_q : pc_rd_s1;

	assign tot_inc = vld_s1 && !req_s1.query && req_s1.inc;
	assign pc_inc  = tot_inc && req_s1.pc_en;

	assign tot_we = busy || tot_inc;
	assign pc_we  = busy || pc_inc;
	assign tot_wa = busy ? clr_q[TOT_AW-1:0] : req_s1.tot_addr;
	assign pc_wa  = busy ? clr_q[PC_AW-1:0] : req_s1.pc_addr;
	assign tot_wd = busy ? '0 : sat_inc(tot_cur);
	assign pc_wd  = busy ? '0 : sat_inc(pc_cur);

	always_ff @(posedge clk) begin
		if (tot_we) begin
			tot_mem[tot_wa] <= tot_wd;
		end
		if (req.valid) begin
			tot_rd_s1 <= tot_mem[req.tot_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pc_we) begin
			pc_mem[pc_wa] <= pc_wd;
		end
		if (req.valid) begin
			pc_rd_s1 <= pc_mem[req.pc_addr];
		end
	end

	assign rsp.valid     = vld_s1 && req_s1.query;
	assign rsp.total     = tot_cur;
	assign rsp.pos_count = req_s1.pc_en ? pc_cur : '0;

	assign stat.busy     = busy;
	assign stat.query_s1 = vld_s1 && req_s1.query;

endmodule

// File: hw/rtl/kpc_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpc_out_fifo
// Small result queue between the counter pipeline and the output channel.
// ----------------------------------------------------------------------------
module kpc_out_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kpc_pkg::mem_rsp_t             push,
	input  logic                          pop_ready,
	output logic                          pop_valid,
	output logic [kpc_pkg::CNT_W-1:0]     pop_total,
	output logic [kpc_pkg::CNT_W-1:0]     pop_pos_count,
	output logic [kpc_pkg::FIFO_CW-1:0]   count
);
	import kpc_pkg::*;

	mem_rsp_t             ent_q [FIFO_DEPTH];
	logic [FIFO_PW-1:0]   wr_ptr_q;
	logic [FIFO_PW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   cnt_q;
	logic                 do_pop;

	function automatic logic [FIFO_PW-1:0] ptr_next(input logic [FIFO_PW-1:0] p);
		ptr_next = (p == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PW'(1);
	endfunction

	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push.valid && !do_pop) begin
				cnt_q <= cnt_q + FIFO_CW'(1);
			end else if (!push.valid && do_pop) begin
				cnt_q <= cnt_q - FIFO_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			ent_q[wr_ptr_q] <= push;
		end
	end

	assign pop_valid     = cnt_q != '0;
	assign pop_total     = ent_q[rd_ptr_q].total;
	assign pop_pos_count = ent_q[rd_ptr_q].pos_count;
	assign count         = cnt_q;

endmodule

// File: hw/rtl/kmer_position_counter_core.sv
`timescale 1ns / 1ps
// Results: a query result passes the stage-1 read register and then the
//   result queue before it is offered on out_valid.
// Throughput: one request per cycle while in_ready is high, pushes and queries
//   alike; the counter memories do a read and a forwarded write-back per cycle.
// Reset: trims, sliding code and run count clear at once; a sweep then
//   zeroes both counter memories, with in_ready low.
// ----------------------------------------------------------------------------
// kmer_position_counter_core
// Streams read bases, codes clean 5-mers, counts them per kmer and start, and answers queries.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kmer_position_counter_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [kpc_pkg::TRIM_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         mode,
	input  logic [7:0]                   base,
	input  logic [7:0]                   position,
	input  logic [2:0]                   trim_status,
	input  logic [8:0]                   seq_len,
	input  logic [kpc_pkg::KMER_W-1:0]   kmer_code,
	input  logic                         query_invalid_set,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [kpc_pkg::CNT_W-1:0]    kmer_total,
	output logic [kpc_pkg::CNT_W-1:0]    start_hits
);
	import kpc_pkg::*;

	localparam int WIN_W = 11;

	logic [TRIM_W-1:0]  left_trim_q;
	logic [TRIM_W-1:0]  right_trim_q;
	logic [KMER_W-1:0]  codes_q;
	logic [RUN_W-1:0]   clean_q;

	logic               acc;
	logic               push;
	logic               query;
	logic [RUN_W-1:0]   clean_base;
	logic [RUN_W-1:0]   clean_nx;
	logic [KMER_W-1:0]  codes_nx;
	logic [7:0]         start;
	logic [TRIM_W-1:0]  lo;
	logic [TRIM_W-1:0]  rt;
	logic signed [WIN_W-1:0] hi;
	logic               in_win;
	logic               set_sel;
	logic [KMER_W-1:0]  kcode;
	logic [7:0]         idx;

	mem_req_t           req;
	mem_rsp_t           rsp;
	mem_stat_t          stat;
	logic [FIFO_CW-1:0] fifo_cnt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_trim_q  <= '0;
			right_trim_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LEFT_TRIM:  left_trim_q  <= cfg_data;
				CFG_RIGHT_TRIM: right_trim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = !stat.busy &&
		(({1'b0, fifo_cnt} + (FIFO_CW + 1)'(stat.query_s1)) < (FIFO_CW + 1)'(FIFO_DEPTH));

	assign acc   = in_valid && in_ready;
	assign query = mode == MODE_QUERY;
	assign push  = acc && mode == MODE_PUSH;

	// position 0 starts a new read
	assign clean_base = (position == '0) ? '0 : clean_q;
	assign clean_nx   = (base == BASE_N) ? '0 :
		(clean_base < RUN_W'(KLEN)) ? clean_base + RUN_W'(1) : clean_base;
	assign codes_nx   = {codes_q[KMER_W-3:0], base[2:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q <= '0;
			clean_q <= '0;
		end else if (push) begin
			codes_q <= codes_nx;
			clean_q <= clean_nx;
		end
	end

	assign start = position - 8'(KLEN - 1);
	assign lo    = (trim_status == ST_LEFT || trim_status == ST_BOTH) ? left_trim_q : '0;
	assign rt    = (trim_status == ST_RIGHT || trim_status == ST_BOTH) ? right_trim_q : '0;
	assign hi    = $signed({2'b00, seq_len}) - WIN_W'(KLEN) - $signed({2'b00, rt});

	assign in_win = clean_nx == RUN_W'(KLEN) && position >= 8'(KLEN - 1) &&
		({1'b0, start} >= lo) && ($signed({3'b000, start}) <= hi);

	assign set_sel = query ? query_invalid_set : (trim_status == ST_INVALID);
	assign kcode   = query ? kmer_code : codes_nx;
	assign idx     = query ? position : start;

	assign req.valid    = acc;
	assign req.query    = query;
	assign req.inc      = in_win;
	assign req.pc_en    = CMP_W'(idx) < CMP_W'(MAX_POS);
	assign req.tot_addr = {set_sel, kcode};
	assign req.pc_addr  = {set_sel, kcode, POS_W'(idx)};

	kpc_count_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.stat   (stat)
	);

	kpc_out_fifo u_fifo (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (rsp),
		.pop_ready     (out_ready),
		.pop_valid     (out_valid),
		.pop_total     (kmer_total),
		.pop_pos_count (start_hits),
		.count         (fifo_cnt)
	);

	`KPC_ASSERT(a_fifo_room, rsp.valid, fifo_cnt != FIFO_CW'(FIFO_DEPTH), "result queue overflow")
	`KPC_ASSERT(a_quiet_clear, stat.busy, !out_valid && !stat.query_s1, "activity during clear")
	`KPC_ASSERT_NXT(a_query_rsp, acc && query, rsp.valid, "query request lost")
	`KPC_ASSERT_NXT(a_push_silent, push, !rsp.valid, "push produced a result")

endmodule
